@@ src/utf8_byte_decoder_unit_macros.svh @@
// Assertion shorthands used by the decoder unit.
`ifndef UTF8_BYTE_DECODER_UNIT_MACROS_SVH
`define UTF8_BYTE_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define U8D_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define U8D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/utf8d_pkg.sv @@
`timescale 1ns / 1ps

package utf8d_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;
  localparam int LEN_W  = 3;
  localparam int DUE_W  = 2;

  localparam logic [CP_W-1:0]  BAD_CHAR = 21'h00003F;
  localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
  localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
  localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
  localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } lead_class_t;

  typedef struct packed {
    logic [DUE_W-1:0] bytes_due;
    logic [CP_W-1:0]  partial_value;
    logic [LEN_W-1:0] sequence_size;
  } dec_state_t;

  typedef struct packed {
    logic             valid;
    logic [CP_W-1:0]  code_point;
    logic             invalid;
    logic [LEN_W-1:0] seq_length;
  } dec_result_t;

  // Sort a byte seen with no sequence open.
  function automatic lead_class_t lead_class(input logic [BYTE_W-1:0] b);
    lead_class_t cls;
    if (b[7] == 1'b0) begin
      cls = LEAD_ASCII;
    end else if (b[7:5] == 3'b110) begin
      cls = LEAD_TWO;
    end else if (b[7:4] == 4'b1110) begin
      cls = LEAD_THREE;
    end else if (b[7:3] == 5'b11110) begin
      cls = LEAD_FOUR;
    end else begin
      cls = LEAD_BAD;
    end
    return cls;
  endfunction

endpackage

@@ src/utf8_byte_decoder_unit.sv @@
`timescale 1ns / 1ps

// Channel  | Dir | Ports                        | Beat carries
// ---------+-----+------------------------------+------------------------------------
// in       | in  | in_tvalid/in_tready/in_tdata | one raw byte of the UTF-8 stream
// out      | out | out_tvalid/out_tready/out_*  | one code point, its length, bad flag
//
// A byte is held in the input register, is decoded by the step logic and,
// where it closes a sequence, lands in the output register; one byte is
// taken per cycle when unstalled.
// Bytes that open or extend a sequence advance the state and leave no beat.
// Reset (rst_n low, synchronous) drops any open sequence and empties both
// registers. An output stall backs up through in_tready in the same cycle.

`include "utf8_byte_decoder_unit_macros.svh"

module utf8_byte_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] seq_length
  output logic [0:0]  out_tuser   // [0] invalid
);

  // Input register stage
  logic                          s1_valid_r;
  logic                          s1_valid_nxt;
  logic [utf8d_pkg::BYTE_W-1:0]  s1_byte_r;

  // Sequence state carried between bytes
  utf8d_pkg::dec_state_t         state_r;
  utf8d_pkg::dec_state_t         state_nxt;

  // Output register
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  utf8d_pkg::dec_result_t        out_res_r;
  utf8d_pkg::dec_result_t        step_res;

  logic out_free;
  logic s1_fire;
  logic in_fire;

  // Terms for the checks at the end
  logic res_bad;
  logic res_ascii;
  logic bad_shape_ok;
  logic len_ok;
  logic ascii_ok;
  logic seq_open;
  logic state_ok;
  logic lead_quiet;

  // The output slot is free when empty or drained this cycle.
  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  utf8d_step u_step (
    .byte_i  (s1_byte_r),
    .state_i (state_r),
    .state_o (state_nxt),
    .res_o   (step_res)
  );

  // Hold the input stage until the step can retire it.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Load a result when the step yields one, drop the beat once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = step_res.valid;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        state_r <= state_nxt;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_tdata;
    end
    if (s1_fire && step_res.valid) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.seq_length, out_res_r.code_point};
  assign out_tuser  = out_res_r.invalid;

  assign res_bad      = out_valid_r && out_res_r.invalid;
  assign res_ascii    = out_valid_r && !out_res_r.invalid
                        && (out_res_r.seq_length == utf8d_pkg::LEN_ONE);
  assign bad_shape_ok = (out_res_r.code_point == utf8d_pkg::BAD_CHAR)
                        && (out_res_r.seq_length == utf8d_pkg::LEN_ONE);
  assign len_ok       = (out_res_r.seq_length == utf8d_pkg::LEN_ONE)
                        || (out_res_r.seq_length == utf8d_pkg::LEN_TWO)
                        || (out_res_r.seq_length == utf8d_pkg::LEN_THREE)
                        || (out_res_r.seq_length == utf8d_pkg::LEN_FOUR);
  assign ascii_ok     = (out_res_r.code_point[20:7] == '0);
  assign seq_open     = (state_r.bytes_due != '0);
  assign state_ok     = ({1'b0, state_r.bytes_due} < state_r.sequence_size);
  assign lead_quiet   = s1_fire && !step_res.valid && (state_r.bytes_due == '0);

  // A bad byte always comes out as a one-byte question mark.
  `U8D_ASSERT_NOW(a_bad_is_qmark, clk, rst_n, res_bad, bad_shape_ok, "bad byte result malformed")

  // Lengths stay within one to four bytes.
  `U8D_ASSERT_NOW(a_len_range, clk, rst_n, out_valid_r, len_ok, "sequence length out of range")

  // A valid one-byte code point is plain ASCII.
  `U8D_ASSERT_NOW(a_ascii_range, clk, rst_n, res_ascii, ascii_ok, "one-byte code point above ASCII")

  // An open sequence always has a size larger than the bytes still due.
  `U8D_ASSERT_NOW(a_state_consistent, clk, rst_n, seq_open, state_ok, "sequence size below bytes due")

  // A lead byte that gives no result must leave a sequence open.
  `U8D_ASSERT_NEXT(a_lead_opens, clk, rst_n, lead_quiet, seq_open, "lead byte did not open a sequence")

endmodule

@@ src/utf8d_step.sv @@
`timescale 1ns / 1ps

// One decode step: next sequence state and the result, if any, for one byte.
module utf8d_step (
  input  logic [utf8d_pkg::BYTE_W-1:0] byte_i,
  input  utf8d_pkg::dec_state_t        state_i,
  output utf8d_pkg::dec_state_t        state_o,
  output utf8d_pkg::dec_result_t       res_o
);

  logic [utf8d_pkg::DUE_W-1:0] due_dec;
  logic [utf8d_pkg::CP_W-1:0]  payload;
  logic [utf8d_pkg::CP_W-1:0]  merged;

  // Place the low six bits by how many bytes remain after this one.
  assign due_dec = state_i.bytes_due - 2'd1;

  always_comb begin
    case (due_dec)
      2'd0:    payload = {15'd0, byte_i[5:0]};
      2'd1:    payload = {9'd0, byte_i[5:0], 6'd0};
      2'd2:    payload = {3'd0, byte_i[5:0], 12'd0};
      default: payload = '0;
    endcase
  end

  assign merged = state_i.partial_value | payload;

  always_comb begin
    state_o = state_i;
    res_o   = '0;
    if (state_i.bytes_due != '0) begin
      if (due_dec == '0) begin
        res_o.valid      = 1'b1;
        res_o.code_point = merged;
        res_o.seq_length = state_i.sequence_size;
        state_o          = '0;
      end else begin
        state_o.bytes_due     = due_dec;
        state_o.partial_value = merged;
      end
    end else begin
      unique case (utf8d_pkg::lead_class(byte_i))
        utf8d_pkg::LEAD_ASCII: begin
          res_o.valid      = 1'b1;
          res_o.code_point = {13'd0, byte_i};
          res_o.seq_length = utf8d_pkg::LEN_ONE;
        end
        utf8d_pkg::LEAD_TWO: begin
          state_o.bytes_due     = 2'd1;
          state_o.partial_value = {10'd0, byte_i[4:0], 6'd0};
          state_o.sequence_size = utf8d_pkg::LEN_TWO;
        end
        utf8d_pkg::LEAD_THREE: begin
          state_o.bytes_due     = 2'd2;
          state_o.partial_value = {5'd0, byte_i[3:0], 12'd0};
          state_o.sequence_size = utf8d_pkg::LEN_THREE;
        end
        utf8d_pkg::LEAD_FOUR: begin
          state_o.bytes_due     = 2'd3;
          state_o.partial_value = {byte_i[2:0], 18'd0};
          state_o.sequence_size = utf8d_pkg::LEN_FOUR;
        end
        default: begin
          res_o.valid      = 1'b1;
          res_o.code_point = utf8d_pkg::BAD_CHAR;
          res_o.invalid    = 1'b1;
          res_o.seq_length = utf8d_pkg::LEN_ONE;
        end
      endcase
    end
  end

endmodule

@@ verif/utf8_byte_decoder_unit_tb.sv @@
`timescale 1ns / 1ps

module utf8_byte_decoder_unit_tb;

  localparam int HOLD_OFF_CYCLES = 80;
  localparam int SETTLE_CYCLES   = 10;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] byte_in
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [20:0] code_point, [23:21] seq_length
  logic [0:0]  out_tuser;  // [0] invalid

  // Decoder state as the bytes have been accepted, and the characters it owes.
  utf8d_pkg::dec_state_t  seq_state;
  utf8d_pkg::dec_result_t pending_chars[$];

  bit sender_idle_on;
  bit receiver_idle_on;
  bit hold_off_request;

  int error_count;
  int bytes_sent;
  int chars_checked;
  int invalid_chars;
  int chars_by_len[5];

  utf8_byte_decoder_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  function automatic utf8d_pkg::lead_class_t classify_lead(input logic [7:0] b);
    casez (b)
      8'b0???????: return utf8d_pkg::LEAD_ASCII;
      8'b110?????: return utf8d_pkg::LEAD_TWO;
      8'b1110????: return utf8d_pkg::LEAD_THREE;
      8'b11110???: return utf8d_pkg::LEAD_FOUR;
      default:     return utf8d_pkg::LEAD_BAD;
    endcase
  endfunction

  function automatic void queue_char(input logic [utf8d_pkg::CP_W-1:0] cp, input logic bad,
                                     input logic [utf8d_pkg::LEN_W-1:0] len);
    utf8d_pkg::dec_result_t ch;
    ch.valid      = 1'b1;
    ch.code_point = cp;
    ch.invalid    = bad;
    ch.seq_length = len;
    pending_chars = {pending_chars, ch};
  endfunction

  // Advance the decoder by one accepted byte.
  function automatic void decode_next_byte(input logic [7:0] b);
    if (seq_state.bytes_due != 0) begin
      // any byte counts as a continuation here, top bits unchecked
      seq_state.bytes_due     = seq_state.bytes_due - 1'b1;
      seq_state.partial_value = seq_state.partial_value
                                | ({15'd0, b[5:0]} << (6 * seq_state.bytes_due));
      if (seq_state.bytes_due == 0) begin
        queue_char(seq_state.partial_value, 1'b0, seq_state.sequence_size);
        seq_state.partial_value = '0;
        seq_state.sequence_size = '0;
      end
      return;
    end
    case (classify_lead(b))
      utf8d_pkg::LEAD_ASCII: begin
        queue_char({13'd0, b}, 1'b0, utf8d_pkg::LEN_ONE);
      end
      utf8d_pkg::LEAD_TWO: begin
        seq_state.partial_value = {16'd0, b[4:0]} << 6;
        seq_state.bytes_due     = 2'd1;
        seq_state.sequence_size = utf8d_pkg::LEN_TWO;
      end
      utf8d_pkg::LEAD_THREE: begin
        seq_state.partial_value = {17'd0, b[3:0]} << 12;
        seq_state.bytes_due     = 2'd2;
        seq_state.sequence_size = utf8d_pkg::LEN_THREE;
      end
      utf8d_pkg::LEAD_FOUR: begin
        seq_state.partial_value = {18'd0, b[2:0]} << 18;
        seq_state.bytes_due     = 2'd3;
        seq_state.sequence_size = utf8d_pkg::LEN_FOUR;
      end
      default: begin
        // stray continuation or 11111xxx lead: state left alone
        queue_char(utf8d_pkg::BAD_CHAR, 1'b1, utf8d_pkg::LEN_ONE);
      end
    endcase
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
    error_count++;
  endtask

  // Offer one byte and hold it until the beat is taken. Called at a rising edge.
  task automatic send_byte(input logic [7:0] b);
    int  gap;
    logic took;
    if (sender_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end while (!took);
    decode_next_byte(b);
    bytes_sent++;
  endtask

  function automatic logic [7:0] continuation_byte();
    // mostly proper 10xxxxxx, now and then any byte at all
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  // Send one character: mostly well-formed, with stray and noise bytes mixed in.
  task automatic send_random_char();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      send_byte({1'b0, 7'($urandom_range(0, 127))});
    end else if (pick < 42) begin
      send_byte({3'b110, 5'($urandom_range(0, 31))});
      send_byte(continuation_byte());
    end else if (pick < 62) begin
      send_byte({4'b1110, 4'($urandom_range(0, 15))});
      repeat (2) send_byte(continuation_byte());
    end else if (pick < 84) begin
      send_byte({5'b11110, 3'($urandom_range(0, 7))});
      repeat (3) send_byte(continuation_byte());
    end else if (pick < 90) begin
      send_byte({2'b10, 6'($urandom_range(0, 63))});
    end else if (pick < 94) begin
      send_byte({5'b11111, 3'($urandom_range(0, 7))});
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_directed_cases();
    logic [7:0] seq_bytes[$] = '{
      8'h00, 8'h7F,                 // ASCII extremes
      8'h80, 8'hF8, 8'hFF,          // stray continuation and bad leads
      8'hC2, 8'hA9,                 // two-byte
      8'hDF, 8'hBF,                 // two-byte, all payload set
      8'hE2, 8'h82, 8'hAC,          // three-byte
      8'hF0, 8'h9F, 8'h98, 8'h80,   // four-byte
      8'hF7, 8'hBF, 8'hBF, 8'hBF,   // widest code point
      8'hC3, 8'hE0,                 // lead byte taken as continuation
      8'hE0, 8'h41, 8'hFF           // ASCII and bad lead swallowed mid-sequence
    };
    foreach (seq_bytes[i]) send_byte(seq_bytes[i]);
  endtask

  task automatic test_random_stream(input int n_bytes);
    int stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) send_random_char();
  endtask

  // Stall the receiver for a long stretch while bytes keep coming.
  task automatic test_output_backpressure(input int n_bytes);
    int stop_at;
    stop_at = bytes_sent + n_bytes;
    sender_idle_on   = 1'b0;
    hold_off_request = 1'b1;
    while (bytes_sent < stop_at) send_random_char();
    sender_idle_on = 1'b1;
  endtask

  task automatic test_full_rate(input int n_bytes);
    sender_idle_on   = 1'b0;
    receiver_idle_on = 1'b0;
    test_random_stream(n_bytes);
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int stall;
    int hold_count;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_request) begin
        out_tready <= 1'b0;
        for (hold_count = 0; hold_count < HOLD_OFF_CYCLES; hold_count++) @(posedge clk);
        hold_off_request = 1'b0;
      end else if (receiver_idle_on && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 10);
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Check each result beat against the oldest owed character.
  always @(negedge clk) begin
    utf8d_pkg::dec_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chars.size() == 0) begin
        $display("[%0t] UNEXPECTED result beat: code point 0x%0h", $realtime,
                 out_tdata[20:0]);
        error_count++;
      end else begin
        want = pending_chars.pop_front();
        if (out_tdata[20:0] !== want.code_point)
          report_mismatch("code_point", out_tdata[20:0], want.code_point);
        if (out_tuser[0] !== want.invalid)
          report_mismatch("invalid", out_tuser[0], want.invalid);
        if (out_tdata[23:21] !== want.seq_length)
          report_mismatch("seq_length", out_tdata[23:21], want.seq_length);
        chars_checked++;
        if (want.invalid) invalid_chars++;
        if (want.seq_length <= 4) chars_by_len[want.seq_length]++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("utf8_byte_decoder_unit test failed");
    $finish;
  end

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_tvalid        = 1'b0;
    in_tdata         = '0;
    seq_state        = '0;
    sender_idle_on   = 1'b1;
    receiver_idle_on = 1'b1;
    hold_off_request = 1'b0;
    error_count      = 0;
    bytes_sent       = 0;
    chars_checked    = 0;
    invalid_chars    = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_random_stream(420);
    test_output_backpressure(100);
    test_full_rate(180);

    in_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_chars.size() != 0) begin
      $display("%0d expected characters never arrived", pending_chars.size());
      error_count++;
    end

    $display("Fed %0d bytes; checked %0d characters (%0d flagged invalid).",
             bytes_sent, chars_checked, invalid_chars);
    $display("Lengths 1/2/3/4: %0d/%0d/%0d/%0d, with a long output stall and a full-rate run.",
             chars_by_len[1], chars_by_len[2], chars_by_len[3], chars_by_len[4]);
    if (error_count == 0) begin
      $display("utf8_byte_decoder_unit test passed");
    end else begin
      $display("utf8_byte_decoder_unit test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/utf8d_pkg.sv
src/utf8d_step.sv
src/utf8_byte_decoder_unit.sv
verif/utf8_byte_decoder_unit_tb.sv
